/* hdl/midi_note_grid_quantizer_macros.svh */
// Assertion macros shared by the quantizer RTL.
`ifndef MIDI_NOTE_GRID_QUANTIZER_MACROS_SVH
`define MIDI_NOTE_GRID_QUANTIZER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MNGQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MNGQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mngq_pkg.sv */
// Shared types and constants of the MIDI note grid quantizer.
`default_nettype none

package mngq_pkg;

    localparam int NOTE_COUNT = 128;
    localparam int NOTE_IDX_W = $clog2(NOTE_COUNT);

    localparam int STATUS_W  = 8;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int TIME_W    = 32;
    localparam int GRID_W    = 20;
    localparam int OFS_W     = GRID_W + 1;
    localparam int SUM_W     = TIME_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam int NCMP_W = ((NOTE_IDX_W > NOTE_W) ? NOTE_IDX_W : NOTE_W) + 1;

    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(120);

    // Message types, taken from the high nibble of the status byte.
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_POLY_TOUCH = 4'hA;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_INTERVAL = 2'd0,
        CFG_WINDOW_START  = 2'd1,
        CFG_WINDOW_END    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic ofs_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/mngq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mngq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/mngq_ctrl.sv */
// Sequencer of the quantizer: handshakes, divider stepping and result hand-off.
`default_nettype none

module mngq_ctrl import mngq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_OFS,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = i_sts.need_div ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_OFS;
                end
            end
            ST_OFS: begin
                o_cmd.ofs_write = 1'b1;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/mngq_dp.sv */
// Datapath of the quantizer: registers, note store, remainder unit and saturating add.
`default_nettype none

module mngq_dp import mngq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [STATUS_W-1:0]  i_status_byte,
    input  wire logic [NOTE_W-1:0]    i_note_number,
    input  wire logic [VEL_W-1:0]     i_velocity,
    input  wire logic [TIME_W-1:0]    i_event_time,
    input  wire logic                 i_first_of_pass,
    output logic      [TIME_W-1:0]    o_new_time,
    output logic                      o_adjusted
);

    // Configuration registers.
    logic [GRID_W-1:0] r_grid;
    logic [TIME_W-1:0] r_win_start;
    logic [TIME_W-1:0] r_win_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid      <= GRID_RESET;
            r_win_start <= '0;
            r_win_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_INTERVAL: r_grid      <= i_cfg_data[GRID_W-1:0];
                CFG_WINDOW_START:  r_win_start <= i_cfg_data[TIME_W-1:0];
                CFG_WINDOW_END:    r_win_end   <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode of the incoming item.
    logic [3:0]            kind;
    logic                  key_on, key_off, touch, in_store;
    logic [NOTE_IDX_W-1:0] in_idx;
    logic                  held_now, vld_now, in_win, need_div, ofs_ok;

    assign kind     = i_status_byte[STATUS_W-1:STATUS_W-4];
    assign key_on   = (kind == KIND_NOTE_ON) && (i_velocity != '0);
    assign key_off  = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (i_velocity == '0));
    assign touch    = (kind == KIND_POLY_TOUCH);
    assign in_store = NCMP_W'(i_note_number) < NCMP_W'(NOTE_COUNT);
    assign in_idx   = NOTE_IDX_W'(i_note_number);

    // Held flags and offset-valid bits; a cleared offset reads as zero.
    logic [NOTE_COUNT-1:0] r_held, n_held;
    logic [NOTE_COUNT-1:0] r_ofs_vld, n_ofs_vld;

    assign held_now = in_store && !i_first_of_pass && r_held[in_idx];
    assign vld_now  = in_store && !i_first_of_pass && r_ofs_vld[in_idx];
    assign in_win   = (key_on || key_off || touch) && (i_event_time > r_win_start) &&
                      ((r_win_end == '0) || (i_event_time < r_win_end));
    assign need_div = key_on && in_store && !held_now;
    assign ofs_ok   = in_win && vld_now;

    always_comb begin
        n_held    = r_held;
        n_ofs_vld = r_ofs_vld;
        if (i_cmd.capture) begin
            if (i_first_of_pass) begin
                n_held    = '0;
                n_ofs_vld = '0;
            end
            if (need_div) begin
                n_held[in_idx]    = 1'b1;
                n_ofs_vld[in_idx] = 1'b1;
            end else if (key_off && in_store) begin
                n_held[in_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_ofs_vld <= '0;
        end else begin
            r_held    <= n_held;
            r_ofs_vld <= n_ofs_vld;
        end
    end

    // Captured item.
    logic [NOTE_IDX_W-1:0] r_idx;
    logic [TIME_W-1:0]     r_time;
    logic                  r_inside, r_need_div, r_ofs_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx      <= in_idx;
            r_time     <= i_event_time;
            r_inside   <= in_win;
            r_need_div <= need_div;
            r_ofs_ok   <= ofs_ok;
        end
    end

    // Restoring remainder, one dividend bit per step.
    logic [GRID_W-1:0]    r_rem, n_rem;
    logic [TIME_W-1:0]    r_dvd;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [GRID_W:0]      rem_sh, grid_ext;

    assign rem_sh   = {r_rem, r_dvd[TIME_W-1]};
    assign grid_ext = {1'b0, r_grid};
    assign n_rem    = (rem_sh >= grid_ext) ? GRID_W'(rem_sh - grid_ext) : GRID_W'(rem_sh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rem <= '0;
            r_dvd <= i_event_time;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_sts.need_div = r_need_div;
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    // Distance to the nearest grid point.
    logic signed [OFS_W-1:0] n_ofs, r_ofs;
    logic        [GRID_W-1:0] half;

    assign half = r_grid >> 1;

    always_comb begin
        priority if ((r_grid == '0) || (r_rem == '0)) begin
            n_ofs = '0;
        end else if (r_rem < half) begin
            n_ofs = -$signed({1'b0, r_rem});
        end else begin
            n_ofs = $signed({1'b0, GRID_W'(r_grid - r_rem)});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ofs_write) begin
            r_ofs <= n_ofs;
        end
    end

    logic [OFS_W-1:0] ram_rdata;

    mngq_ram #(
        .WIDTH (OFS_W),
        .DEPTH (NOTE_COUNT)
    ) u_ofs_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ofs_write),
        .i_waddr (r_idx),
        .i_wdata (n_ofs),
        .i_re    (i_cmd.capture),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // Move the time and clamp it to the unsigned range.
    logic signed [OFS_W-1:0] off;
    logic signed [SUM_W-1:0] sum;
    logic        [TIME_W-1:0] sat;

    always_comb begin
        priority if (!r_inside) begin
            off = '0;
        end else if (r_need_div) begin
            off = r_ofs;
        end else if (r_ofs_ok) begin
            off = $signed(ram_rdata);
        end else begin
            off = '0;
        end
    end

    assign sum = $signed({2'b00, r_time}) + $signed({{(SUM_W-OFS_W){off[OFS_W-1]}}, off});

    always_comb begin
        priority if (sum[SUM_W-1]) begin
            sat = '0;
        end else if (sum[TIME_W]) begin
            sat = '1;
        end else begin
            sat = sum[TIME_W-1:0];
        end
    end

    logic [TIME_W-1:0] r_new_time;
    logic              r_adjusted;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_new_time <= sat;
            r_adjusted <= r_inside;
        end
    end

    assign o_new_time = r_new_time;
    assign o_adjusted = r_adjusted;

endmodule

`default_nettype wire

/* hdl/midi_note_grid_quantizer.sv */
// MIDI note grid quantizer: top level joining the sequencer and the datapath.
//
// Usage: MIDI events enter one item at a time on the input channel
// (i_in_valid / o_in_ready) with status byte, note, velocity, time stamp and
// a pass-start flag. Each item gives exactly one result item on the output
// channel (o_out_valid / i_out_ready): the moved time and an adjusted flag.
// A key-on for a note that is not held finds the time modulo the grid with a
// one-bit-per-cycle restoring remainder unit of 32 steps, one per dividend
// bit; every other item skips that unit. Items are worked on one at a time;
// the next item can be accepted as soon as the current result sits in the
// output register, even while the receiver has not taken it. If the receiver
// stalls, the finished item waits in the output register, and the following
// item waits at its last step until the register frees up.
// Reset (synchronous, active low) restores the grid to 120 ticks, clears the
// window bounds, and clears every held flag and offset-valid bit at once, so
// every stored offset reads as zero; there is no clearing pass.
// Configuration writes are taken at any cycle but are meant for times when no
// item is in flight.
`default_nettype none

`include "midi_note_grid_quantizer_macros.svh"

module midi_note_grid_quantizer import mngq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [STATUS_W-1:0]  i_status_byte,
    input  wire logic [NOTE_W-1:0]    i_note_number,
    input  wire logic [VEL_W-1:0]     i_velocity,
    input  wire logic [TIME_W-1:0]    i_event_time,
    input  wire logic                 i_first_of_pass,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [TIME_W-1:0]    o_new_time,
    output logic                      o_adjusted
);

    // Command and status bundles between the sequencer and the datapath.
    t_cmd w_cmd;
    t_sts w_sts;

    mngq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mngq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_status_byte   (i_status_byte),
        .i_note_number   (i_note_number),
        .i_velocity      (i_velocity),
        .i_event_time    (i_event_time),
        .i_first_of_pass (i_first_of_pass),
        .o_new_time      (o_new_time),
        .o_adjusted      (o_adjusted)
    );

    // An accepted item keeps the block busy for at least the next cycle.
    `MNGQ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted twice in a row")

    // An offset is only written for a first key-on that ran the remainder unit.
    `MNGQ_ASSERT_IMP(a_write_needs_div, i_clk, i_rst_n, w_cmd.ofs_write, w_sts.need_div, "offset written without a new key-on")

    // A new result never overwrites one the receiver has not taken.
    `MNGQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_out_valid || i_out_ready, "result register overwritten")

    // A result is loaded only after the item's work has left the input side.
    `MNGQ_ASSERT_IMP(a_load_not_idle, i_clk, i_rst_n, w_cmd.out_load, !o_in_ready, "result loaded while idle")

endmodule

`default_nettype wire
